// ----- rtl/core/v3alu_pkg.sv -----
`timescale 1ns / 1ps
package v3alu_pkg;

   localparam int COMP_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int CW = COMP_WIDTH_DEF;
   localparam int OP_WIDTH = 3;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_MAG   = 3'd2,
      OP_DOT   = 3'd3,
      OP_CROSS = 3'd4,
      OP_UNIT  = 3'd5,
      OP_SCALE = 3'd6,
      OP_NONE  = 3'd7
   } op_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      logic signed [CW-1:0] ax;
      logic signed [CW-1:0] ay;
      logic signed [CW-1:0] az;
      logic signed [CW-1:0] bx;
      logic signed [CW-1:0] by_comp;
      logic signed [CW-1:0] bz;
      logic signed [CW-1:0] factor;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] rx;
      logic signed [CW-1:0] ry;
      logic signed [CW-1:0] rz;
      logic signed [CW-1:0] scalar_out;
      logic saturated;
      logic zero_length;
   } rsp_type;

endpackage

// ----- rtl/core/v3alu_front.sv -----
`timescale 1ns / 1ps
// Front stage: registers one request into a two-entry skid queue.
module v3alu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  v3alu_pkg::req_type  req_data,
   output logic                q_valid,
   input  logic                q_stall,
   output v3alu_pkg::req_type  q_data
);
   import v3alu_pkg::*;

   req_type slot_ff [2];
   req_type slot_in [2];
   logic    rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign req_stall = (cnt_ff == 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = slot_ff[rd_ptr_ff];
   assign push = req_valid && !req_stall;
   assign pop  = q_valid && !q_stall;

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = req_data;
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) rd_ptr_in = !rd_ptr_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end
endmodule

// ----- rtl/core/v3alu_back.sv -----
`timescale 1ns / 1ps
// Back end: fixed-depth pipeline, advances as a whole when not stalled.
// S1 products (32x32 each), S2 sums/shift/clip, S3..S34 root bits,
// then FRAC_BITS+1 divide steps, final sign/clip and output register.
module v3alu_back #(
   parameter int FRAC_BITS  = v3alu_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_stall,
   input  v3alu_pkg::req_type  q_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output v3alu_pkg::rsp_type  rsp_data
);
   import v3alu_pkg::*;

   localparam int W   = CW;
   localparam int PW  = 2 * W;          // product width
   localparam int SW  = PW + 2;         // sum of three products
   localparam int RB  = W;              // root bits (root < 2^W)
   localparam int DS  = FRAC_BITS + 1;  // divide steps
   localparam int NST = 2 + RB + DS + 1;
   localparam int RW  = W + 1;          // remainder width
   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      logic signed [W-1:0] c0, c1, c2, sc;
      logic sat;
      logic [SW-1:0] sq;        // sum of squares, then root remainder
      logic [RB-1:0] root;
      logic [W-1:0] a0, a1, a2; // magnitudes of a
      logic s0, s1, s2;         // signs of a
      logic [DS-1:0] q0, q1, q2;
      logic [RW-1:0] r0, r1, r2;
   } st_type;

   st_type pipe_ff [NST];
   st_type pipe_in [NST];
   logic   vld_ff [NST];
   logic   advance;

   assign advance   = !(vld_ff[NST-1] && rsp_stall);
   assign q_stall   = !advance;
   assign rsp_valid = vld_ff[NST-1];
   assign rsp_data.rx = pipe_ff[NST-1].c0[W-1:0];
   assign rsp_data.ry = pipe_ff[NST-1].c1[W-1:0];
   assign rsp_data.rz = pipe_ff[NST-1].c2[W-1:0];
   assign rsp_data.scalar_out = pipe_ff[NST-1].sc[W-1:0];
   assign rsp_data.saturated  = pipe_ff[NST-1].sat;
   assign rsp_data.zero_length = (pipe_ff[NST-1].op == OP_UNIT) && (pipe_ff[NST-1].root == '0);

   // products held in stage 0
   logic signed [PW-1:0] p_ff [9];
   logic signed [PW-1:0] p_in [9];
   logic signed [W-1:0] ax, ay, az, bx, by, bz, fc;

   function automatic logic [W:0] clip_f(input logic signed [SW-1:0] v);
      logic hi, lo;
      hi = v > $signed({{(SW-W){1'b0}}, MAXV});
      lo = v < $signed({{(SW-W){1'b1}}, MINV});
      if (hi) return {1'b1, MAXV};
      if (lo) return {1'b1, MINV};
      return {1'b0, v[W-1:0]};
   endfunction

   always_comb begin
      ax = q_data.ax[W-1:0]; ay = q_data.ay[W-1:0]; az = q_data.az[W-1:0];
      bx = q_data.bx[W-1:0]; by = q_data.by_comp[W-1:0]; bz = q_data.bz[W-1:0];
      fc = q_data.factor[W-1:0];
      p_in[0] = (q_data.op == OP_DOT) ? ax * bx : ax * ax;
      p_in[1] = (q_data.op == OP_DOT) ? ay * by : ay * ay;
      p_in[2] = (q_data.op == OP_DOT) ? az * bz : az * az;
      p_in[3] = (q_data.op == OP_SCALE) ? ax * fc : ay * bz;
      p_in[4] = (q_data.op == OP_SCALE) ? ay * fc : az * by;
      p_in[5] = (q_data.op == OP_SCALE) ? az * fc : bx * az;
      p_in[6] = ax * bz;
      p_in[7] = ax * by;
      p_in[8] = ay * bx;
      pipe_in[0] = '0;
      pipe_in[0].op = q_data.op;
      pipe_in[0].c0 = ax; pipe_in[0].c1 = ay; pipe_in[0].c2 = az;
      pipe_in[0].sc = bx; // b kept for add/sub
      pipe_in[0].q0 = '0;
      pipe_in[0].a0 = by; pipe_in[0].a1 = bz;
   end

   // stage 1: combine and clip
   logic signed [SW-1:0] e0, e1, e2, es;
   logic [W:0] k0, k1, k2, ks;
   always_comb begin
      st_type s;
      s = pipe_ff[0];
      pipe_in[1] = '0;
      pipe_in[1].op = s.op;
      e0 = '0; e1 = '0; e2 = '0; es = '0;
      case (s.op)
         OP_ADD: begin
            e0 = SW'(s.c0) + SW'(s.sc);
            e1 = SW'(s.c1) + SW'($signed(s.a0));
            e2 = SW'(s.c2) + SW'($signed(s.a1));
         end
         OP_SUB: begin
            e0 = SW'(s.c0) - SW'(s.sc);
            e1 = SW'(s.c1) - SW'($signed(s.a0));
            e2 = SW'(s.c2) - SW'($signed(s.a1));
         end
         OP_DOT: es = (SW'(p_ff[0]) + SW'(p_ff[1]) + SW'(p_ff[2])) >>> FRAC_BITS;
         OP_CROSS: begin
            e0 = (SW'(p_ff[3]) - SW'(p_ff[4])) >>> FRAC_BITS;
            e1 = (SW'(p_ff[5]) - SW'(p_ff[6])) >>> FRAC_BITS;
            e2 = (SW'(p_ff[7]) - SW'(p_ff[8])) >>> FRAC_BITS;
         end
         OP_SCALE: begin
            e0 = SW'(p_ff[3]) >>> FRAC_BITS;
            e1 = SW'(p_ff[4]) >>> FRAC_BITS;
            e2 = SW'(p_ff[5]) >>> FRAC_BITS;
         end
         default: ;
      endcase
      k0 = clip_f(e0); k1 = clip_f(e1); k2 = clip_f(e2); ks = clip_f(es);
      pipe_in[1].c0 = k0[W-1:0]; pipe_in[1].c1 = k1[W-1:0];
      pipe_in[1].c2 = k2[W-1:0]; pipe_in[1].sc = ks[W-1:0];
      pipe_in[1].sat = k0[W] | k1[W] | k2[W] | ks[W];
      pipe_in[1].sq = SW'(p_ff[0]) + SW'(p_ff[1]) + SW'(p_ff[2]);
      pipe_in[1].s0 = s.c0[W-1]; pipe_in[1].s1 = s.c1[W-1]; pipe_in[1].s2 = s.c2[W-1];
      pipe_in[1].a0 = s.c0[W-1] ? W'(-s.c0) : W'(s.c0);
      pipe_in[1].a1 = s.c1[W-1] ? W'(-s.c1) : W'(s.c1);
      pipe_in[1].a2 = s.c2[W-1] ? W'(-s.c2) : W'(s.c2);
   end

   // root stages: one bit each, MSB first
   // sq holds n - root^2; setting bit B costs root * 2^(B+1) + 2^(2B)
   genvar g;
   generate
      for (g = 0; g < RB; g++) begin : g_root
         localparam int B = RB - 1 - g;
         logic [RB-1:0] cand;
         logic [SW-1:0] trial;
         always_comb begin
            pipe_in[2+g] = pipe_ff[1+g];
            cand  = pipe_ff[1+g].root | (RB'(1) << B);
            trial = (SW'(pipe_ff[1+g].root) << (B + 1)) | (SW'(1) << (2 * B));
            if (pipe_ff[1+g].sq >= trial) begin
               pipe_in[2+g].root = cand;
               pipe_in[2+g].sq   = pipe_ff[1+g].sq - trial;
            end
         end
      end
   endgenerate

   // divide stages: first step is the integer bit, then fraction bits
   function automatic logic [RW+DS-1:0] dstep(input logic [RW-1:0] r,
                                              input logic [DS-1:0] q,
                                              input logic [RB-1:0] m,
                                              input logic first);
      logic [RW:0] t;
      logic [DS-1:0] qn;
      t  = first ? {1'b0, r} : {r, 1'b0};
      qn = {q[DS-2:0], 1'b0};
      if (t >= (RW+1)'(m)) begin
         t = t - (RW+1)'(m);
         qn[0] = 1'b1;
      end
      return {t[RW-1:0], qn};
   endfunction

   generate
      for (g = 0; g < DS; g++) begin : g_div
         localparam int I = 2 + RB + g;
         logic [RW+DS-1:0] d0, d1, d2;
         st_type s;
         always_comb begin
            s = pipe_ff[I-1];
            if (g == 0) begin
               s.r0 = RW'(s.a0); s.r1 = RW'(s.a1); s.r2 = RW'(s.a2);
               s.q0 = '0; s.q1 = '0; s.q2 = '0;
            end
            d0 = dstep(s.r0, s.q0, s.root, g == 0);
            d1 = dstep(s.r1, s.q1, s.root, g == 0);
            d2 = dstep(s.r2, s.q2, s.root, g == 0);
            pipe_in[I] = s;
            {pipe_in[I].r0, pipe_in[I].q0} = d0;
            {pipe_in[I].r1, pipe_in[I].q1} = d1;
            {pipe_in[I].r2, pipe_in[I].q2} = d2;
         end
      end
   endgenerate

   // final: pick result per op
   function automatic logic [W:0] uclip(input logic [DS-1:0] q, input logic neg);
      logic signed [DS+1:0] v;
      logic signed [SW-1:0] e;
      v = neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
      e = SW'(v);
      return clip_f(e);
   endfunction

   logic [W:0] u0, u1, u2, mg;
   always_comb begin
      st_type s;
      s = pipe_ff[NST-2];
      pipe_in[NST-1] = s;
      u0 = uclip(s.q0, s.s0);
      u1 = uclip(s.q1, s.s1);
      u2 = uclip(s.q2, s.s2);
      mg = clip_f(SW'({1'b0, s.root}));
      case (s.op)
         OP_MAG: begin
            pipe_in[NST-1].c0 = '0; pipe_in[NST-1].c1 = '0; pipe_in[NST-1].c2 = '0;
            pipe_in[NST-1].sc = mg[W-1:0];
            pipe_in[NST-1].sat = mg[W];
         end
         OP_UNIT: begin
            pipe_in[NST-1].sc = '0;
            if (s.root == '0) begin
               pipe_in[NST-1].c0 = '0; pipe_in[NST-1].c1 = '0; pipe_in[NST-1].c2 = '0;
               pipe_in[NST-1].sat = 1'b0;
            end else begin
               pipe_in[NST-1].c0 = u0[W-1:0];
               pipe_in[NST-1].c1 = u1[W-1:0];
               pipe_in[NST-1].c2 = u2[W-1:0];
               pipe_in[NST-1].sat = u0[W] | u1[W] | u2[W];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff <= pipe_in;
         p_ff    <= p_in;
      end
      if (reset) begin
         for (int i = 0; i < NST; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= q_valid;
         for (int i = 1; i < NST; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end
endmodule

// ----- rtl/core/vector3_alu.sv -----
`timescale 1ns / 1ps
// vector3_alu: Q16.16 three-component vector ALU.
// Request channel: req_valid / req_stall / req_data (op, a, b, factor).
// Response channel: rsp_valid / rsp_stall / rsp_data (vector, scalar, flags).
// A request is taken on a clock edge with valid high and stall low.
// Ops: add, subtract, magnitude, dot, cross, unit vector, scale;
// op 7 returns zeros. Results clip to the signed range and set saturated.
// Unit vector of a zero vector returns zeros with zero_length set.
// Throughput: one request per cycle, every op, while not stalled.
// From acceptance to rsp_valid a request passes the front queue, one
// product stage, one combine stage, one stage per root bit and FRAC_BITS+1
// divide stages, the last feeding the output register.
// When rsp_stall holds with rsp_valid high, the back pipeline freezes;
// the two-entry front queue absorbs requests, then raises req_stall.
// Reset (synchronous) empties the queue and pipeline; no other state.
module vector3_alu #(
   parameter int FRAC_BITS  = v3alu_pkg::FRAC_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  v3alu_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output v3alu_pkg::rsp_type  rsp_data
);
   import v3alu_pkg::*;

   logic    q_valid, q_stall;
   req_type q_data;

   v3alu_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .q_valid, .q_stall, .q_data
   );

   v3alu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock, .reset, .q_valid, .q_stall, .q_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
